// ===== design/terminal_line_editor_macros.svh =====
// Assertion macros used by the line editor top level.
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define TLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tle_pkg.sv =====
// Types and constants of the terminal line editor.
package tle_pkg;

    // Item selector codes.
    localparam logic [1:0] FUNC_KEY   = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Key codes that the editor recognises.
    localparam logic [7:0] KEY_NONE    = 8'd0;
    localparam logic [7:0] KEY_BS      = 8'd8;
    localparam logic [7:0] KEY_NL      = 8'd10;
    localparam logic [7:0] KEY_ESC     = 8'd27;
    localparam logic [7:0] KEY_SPACE   = 8'd32;
    localparam logic [7:0] KEY_UP      = 8'd65;
    localparam logic [7:0] KEY_RIGHT   = 8'd67;
    localparam logic [7:0] KEY_LEFT    = 8'd68;
    localparam logic [7:0] KEY_BRACKET = 8'd91;
    localparam logic [7:0] KEY_TILDE   = 8'd126;
    localparam logic [7:0] KEY_DEL     = 8'd127;

    // Output beat numbers; a single-byte result is shown at the last beat only.
    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_LAST  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ESC     = 2'd1,
        PH_BRACKET = 2'd2
    } t_phase;

    // What the edit logic decides for one item.
    typedef struct packed {
        logic       triple;
        logic       echo_valid;
        logic       enter;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       rd_ok;
        logic       wr_en;
        logic [7:0] wr_data;
    } t_edit_out;

endpackage

// ===== design/tle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tle_edit.sv =====
// Next-state and result decision of the line editor for one item.
module tle_edit
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 256,
    parameter int CW            = 9,
    parameter int AW            = 8
) (
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_key_code,
    input  logic [7:0]    i_read_index,
    input  t_phase        i_phase,
    input  logic [CW-1:0] i_cursor,
    input  logic [CW-1:0] i_length,
    output t_phase        o_phase,
    output logic [CW-1:0] o_cursor,
    output logic [CW-1:0] o_length,
    output logic [AW-1:0] o_wr_addr,
    output t_edit_out     o_res
);

    localparam int IW = (CW > 8) ? CW : 8;

    logic handled;
    logic [IW-1:0] idx_ext;
    logic [IW-1:0] len_ext;

    assign idx_ext = IW'(i_read_index);
    assign len_ext = IW'(i_length);

    always_comb begin
        handled   = 1'b0;
        o_phase   = i_phase;
        o_cursor  = i_cursor;
        o_length  = i_length;
        o_wr_addr = i_cursor[AW-1:0];
        o_res     = '0;
        case (i_func)
            FUNC_KEY: begin
                if (i_key_code != KEY_NONE) begin
                    if (i_phase != PH_IDLE) begin
                        if (i_key_code == KEY_BRACKET) begin
                            o_phase = PH_BRACKET;
                            handled = 1'b1;
                        end else if (i_phase == PH_BRACKET && i_key_code == KEY_LEFT) begin
                            o_phase = PH_IDLE;
                            handled = 1'b1;
                            if (i_cursor != '0) begin
                                o_cursor         = i_cursor - 1'b1;
                                o_res.triple     = 1'b1;
                                o_res.echo_valid = 1'b1;
                                o_res.ch0        = KEY_ESC;
                                o_res.ch1        = KEY_BRACKET;
                                o_res.ch2        = KEY_LEFT;
                            end
                        end else if (i_phase == PH_BRACKET && i_key_code == KEY_RIGHT) begin
                            o_phase = PH_IDLE;
                            handled = 1'b1;
                            if (i_cursor < i_length) begin
                                o_cursor         = i_cursor + 1'b1;
                                o_res.triple     = 1'b1;
                                o_res.echo_valid = 1'b1;
                                o_res.ch0        = KEY_ESC;
                                o_res.ch1        = KEY_BRACKET;
                                o_res.ch2        = KEY_RIGHT;
                            end
                        end else if (i_phase == PH_BRACKET && i_key_code == KEY_UP) begin
                            o_phase = PH_IDLE;
                            handled = 1'b1;
                        end else begin
                            o_phase = PH_IDLE;
                        end
                    end
                    if (!handled) begin
                        if (i_key_code == KEY_DEL || i_key_code == KEY_BS) begin
                            if (i_cursor != '0 && i_length != '0) begin
                                o_cursor         = i_cursor - 1'b1;
                                o_length         = i_length - 1'b1;
                                o_res.triple     = 1'b1;
                                o_res.echo_valid = 1'b1;
                                o_res.ch0        = KEY_BS;
                                o_res.ch1        = KEY_SPACE;
                                o_res.ch2        = KEY_BS;
                            end
                        end else if (i_key_code == KEY_ESC) begin
                            o_phase = PH_ESC;
                        end else if (i_key_code == KEY_NL) begin
                            o_res.enter = 1'b1;
                        end else if (i_key_code >= KEY_SPACE && i_key_code <= KEY_TILDE) begin
                            if (i_cursor < i_length) begin
                                o_wr_addr        = i_cursor[AW-1:0];
                                o_cursor         = i_cursor + 1'b1;
                                o_res.wr_en      = 1'b1;
                                o_res.wr_data    = i_key_code;
                                o_res.echo_valid = 1'b1;
                                o_res.ch2        = i_key_code;
                            end else if (i_length != CW'(LINE_CAPACITY)) begin
                                o_wr_addr        = i_length[AW-1:0];
                                o_length         = i_length + 1'b1;
                                o_cursor         = i_length + 1'b1;
                                o_res.wr_en      = 1'b1;
                                o_res.wr_data    = i_key_code;
                                o_res.echo_valid = 1'b1;
                                o_res.ch2        = i_key_code;
                            end
                        end
                    end
                end
            end
            FUNC_FLUSH: begin
                o_cursor = '0;
                o_length = '0;
            end
            FUNC_READ: begin
                o_res.rd_ok = (idx_ext < len_ext);
            end
            default: begin
                o_res.rd_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/terminal_line_editor.sv =====
// Top level of the terminal line editor: input register, editing state, line store, result stage.
//
// The editor takes one item per transfer: a keystroke, a flush of the line or a read of one
// byte of the line store. Every item is registered on acceptance and decided once the result
// stage is free (cursor, length, escape phase and a possible store write all update at that
// edge), and loaded into the result stage at the same edge. A cursor move (ESC [ D or ESC [ C)
// that moves the cursor, or a backspace or delete that removes a byte, gives three result
// transfers, one echoed byte per cycle while the receiver does not stall; every other item
// gives exactly one. The last flag marks the final transfer of an item. The three-byte echo
// sequencer on the output side sets the rate: a three-byte echo holds the result stage until
// its last byte leaves, and the input register accepts the next item while the current
// result is still being sent. Reads return the byte from the line store, or zero at or beyond
// the current length; the store itself is never cleared and only positions below the length
// are ever returned. Appends beyond LINE_CAPACITY bytes are refused without echo; the cursor
// and length outputs carry the state after the item, resized to nine bits.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_key_code,
    input  logic [7:0] i_read_index,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_echo_char,
    output logic       o_echo_valid,
    output logic       o_last,
    output logic       o_enter_seen,
    output logic [8:0] o_cursor_pos,
    output logic [8:0] o_line_length,
    output logic [7:0] o_read_char
);

    // Cursor and length can reach the capacity itself; store addresses cannot.
    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int AW = $clog2(LINE_CAPACITY);

    // Input register.
    logic       r_s1_valid;
    logic [1:0] r_func;
    logic [7:0] r_key;
    logic [7:0] r_idx;

    // Editing state.
    t_phase        r_phase;
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] r_length;

    // Result stage.
    logic       r_res_valid;
    logic [1:0] r_beat;
    logic [7:0] r_ch [3];
    logic       r_echo_valid;
    logic       r_enter;
    logic       r_rd_ok;

    t_phase        n_phase;
    logic [CW-1:0] n_cursor;
    logic [CW-1:0] n_length;
    logic [AW-1:0] wr_addr;
    t_edit_out     edit;

    logic       in_accept;
    logic       out_accept;
    logic       res_free;
    logic       res_load;
    logic [7:0] rd_data;

    // The result stage can take a new item when it is empty or its last beat leaves now.
    assign out_accept = r_res_valid && !i_out_stall;
    assign res_free   = !r_res_valid || (out_accept && r_beat == BEAT_LAST);
    assign res_load   = r_s1_valid && res_free;
    assign o_in_stall = r_s1_valid && !res_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    tle_edit #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .CW            (CW),
        .AW            (AW)
    ) u_edit (
        .i_func       (r_func),
        .i_key_code   (r_key),
        .i_read_index (r_idx),
        .i_phase      (r_phase),
        .i_cursor     (r_cursor),
        .i_length     (r_length),
        .o_phase      (n_phase),
        .o_cursor     (n_cursor),
        .o_length     (n_length),
        .o_wr_addr    (wr_addr),
        .o_res        (edit)
    );

    // The read port only moves when a new result is loaded, so the read data holds while the
    // result channel is stalled. An item that writes the store never has its read byte returned.
    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (res_load && edit.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (edit.wr_data),
        .i_rd_en   (res_load),
        .i_rd_addr (AW'(r_idx)),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_cursor    <= '0;
            r_length    <= '0;
            r_res_valid <= 1'b0;
            r_beat      <= BEAT_FIRST;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (res_load) begin
                r_s1_valid <= 1'b0;
            end

            if (res_load) begin
                r_phase     <= n_phase;
                r_cursor    <= n_cursor;
                r_length    <= n_length;
                r_res_valid <= 1'b1;
                r_beat      <= edit.triple ? BEAT_FIRST : BEAT_LAST;
            end else if (out_accept) begin
                if (r_beat == BEAT_LAST) begin
                    r_res_valid <= 1'b0;
                end else begin
                    r_beat <= r_beat + 1'b1;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= i_func;
            r_key  <= i_key_code;
            r_idx  <= i_read_index;
        end
        if (res_load) begin
            r_ch[0]      <= edit.ch0;
            r_ch[1]      <= edit.ch1;
            r_ch[2]      <= edit.ch2;
            r_echo_valid <= edit.echo_valid;
            r_enter      <= edit.enter;
            r_rd_ok      <= edit.rd_ok;
        end
    end

    // The editing state only changes when a result is loaded, so it is the state after the
    // item being shown for every transfer of that item.
    assign o_out_valid   = r_res_valid;
    assign o_echo_char   = r_ch[r_beat];
    assign o_echo_valid  = r_echo_valid;
    assign o_last        = (r_beat == BEAT_LAST);
    assign o_enter_seen  = r_enter;
    assign o_cursor_pos  = 9'(r_cursor);
    assign o_line_length = 9'(r_length);
    assign o_read_char   = r_rd_ok ? rd_data : 8'd0;

    `include "terminal_line_editor_macros.svh"

    `TLE_ASSERT_ALWAYS(a_cursor_within_line, r_cursor <= r_length, "cursor beyond line length")
    `TLE_ASSERT_ALWAYS(a_length_within_capacity, r_length <= CW'(LINE_CAPACITY), "line overflow")
    `TLE_ASSERT_NEXT(a_beat_advances, out_accept && r_beat != BEAT_LAST, r_res_valid && r_beat == $past(r_beat) + 2'd1, "echo beat skipped")
    `TLE_ASSERT_NEXT(a_single_at_last_beat, res_load && !edit.triple, r_res_valid && r_beat == BEAT_LAST, "single result not marked last")
    `TLE_ASSERT_NEXT(a_no_bracket_from_idle, res_load && r_phase == PH_IDLE, r_phase != PH_BRACKET, "escape phase skipped ESC")

endmodule

// ===== tb/sv/line_editor_check_pkg.sv =====
// Scoreboard for the terminal line editor: line state, predicted results and their checking.
package line_editor_check_pkg;
    import tle_pkg::*;

    localparam int LINE_CAP = 256;
    // Selector code that the editor does not use.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] echo_char;
        logic       echo_valid;
        logic       last;
        logic       enter_seen;
        logic [8:0] cursor_pos;
        logic [8:0] line_length;
        logic [7:0] read_char;
    } line_result_t;

    class line_scoreboard;
        t_phase       phase;
        logic [8:0]   cur_pos;
        logic [8:0]   line_len;
        logic [7:0]   line_bytes [LINE_CAP];
        line_result_t expected_q [$];
        int           mismatches;

        function new();
            phase      = PH_IDLE;
            cur_pos    = '0;
            line_len   = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [8:0] get_len();
            return line_len;
        endfunction

        // Each result carries the cursor and length after the item.
        function void push_result(logic [7:0] ch, logic ev, logic fin, logic ent,
                                  logic [7:0] rd);
            line_result_t r;
            r.echo_char   = ch;
            r.echo_valid  = ev;
            r.last        = fin;
            r.enter_seen  = ent;
            r.cursor_pos  = cur_pos;
            r.line_length = line_len;
            r.read_char   = rd;
            expected_q.push_back(r);
        endfunction

        function void push_status();
            push_result(8'd0, 1'b0, 1'b1, 1'b0, 8'd0);
        endfunction

        function void push_echo3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
            push_result(a, 1'b1, 1'b0, 1'b0, 8'd0);
            push_result(b, 1'b1, 1'b0, 1'b0, 8'd0);
            push_result(c, 1'b1, 1'b1, 1'b0, 8'd0);
        endfunction

        function void predict_key(logic [7:0] key);
            if (key == KEY_NONE) begin
                push_status();
                return;
            end
            if (phase != PH_IDLE) begin
                if (key == KEY_BRACKET) begin
                    phase = PH_BRACKET;
                    push_status();
                    return;
                end
                if (phase == PH_BRACKET) begin
                    if (key == KEY_LEFT) begin
                        phase = PH_IDLE;
                        if (cur_pos > 0) begin
                            cur_pos = cur_pos - 1;
                            push_echo3(KEY_ESC, KEY_BRACKET, KEY_LEFT);
                        end else begin
                            push_status();
                        end
                        return;
                    end
                    if (key == KEY_RIGHT) begin
                        phase = PH_IDLE;
                        if (cur_pos < line_len) begin
                            cur_pos = cur_pos + 1;
                            push_echo3(KEY_ESC, KEY_BRACKET, KEY_RIGHT);
                        end else begin
                            push_status();
                        end
                        return;
                    end
                    if (key == KEY_UP) begin
                        phase = PH_IDLE;
                        push_status();
                        return;
                    end
                end
                // A broken sequence falls through and the key is handled as usual.
                phase = PH_IDLE;
            end
            if (key == KEY_DEL || key == KEY_BS) begin
                if (cur_pos > 0 && line_len > 0) begin
                    cur_pos  = cur_pos - 1;
                    line_len = line_len - 1;
                    push_echo3(KEY_BS, KEY_SPACE, KEY_BS);
                end else begin
                    push_status();
                end
                return;
            end
            if (key == KEY_ESC) begin
                phase = PH_ESC;
                push_status();
                return;
            end
            if (key == KEY_NL) begin
                push_result(8'd0, 1'b0, 1'b1, 1'b1, 8'd0);
                return;
            end
            if (key >= KEY_SPACE && key <= KEY_TILDE) begin
                if (cur_pos < line_len) begin
                    line_bytes[cur_pos[7:0]] = key;
                    cur_pos = cur_pos + 1;
                end else begin
                    if (line_len >= LINE_CAP) begin
                        push_status();
                        return;
                    end
                    line_bytes[line_len[7:0]] = key;
                    line_len = line_len + 1;
                    cur_pos  = line_len;
                end
                push_result(key, 1'b1, 1'b1, 1'b0, 8'd0);
                return;
            end
            push_status();
        endfunction

        function void note_item(logic [1:0] func, logic [7:0] key, logic [7:0] idx);
            case (func)
                FUNC_KEY: predict_key(key);
                FUNC_FLUSH: begin
                    cur_pos  = '0;
                    line_len = '0;
                    push_status();
                end
                FUNC_READ: begin
                    push_result(8'd0, 1'b0, 1'b1, 1'b0,
                                ({1'b0, idx} < line_len) ? line_bytes[idx] : 8'd0);
                end
                default: push_status();
            endcase
        endfunction

        function void check_result(line_result_t got);
            line_result_t want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("Unexpected result transfer: echo=%0d/%0b last=%0b enter=%0b cursor=%0d length=%0d read=%0d",
                             got.echo_char, got.echo_valid, got.last, got.enter_seen,
                             got.cursor_pos, got.line_length, got.read_char);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (want.echo_char !== got.echo_char || want.echo_valid !== got.echo_valid ||
                want.last !== got.last || want.enter_seen !== got.enter_seen ||
                want.cursor_pos !== got.cursor_pos || want.line_length !== got.line_length ||
                want.read_char !== got.read_char) begin
                if (mismatches < 10) begin
                    $display("Mismatch: expected echo=%0d/%0b last=%0b enter=%0b cursor=%0d length=%0d read=%0d",
                             want.echo_char, want.echo_valid, want.last, want.enter_seen,
                             want.cursor_pos, want.line_length, want.read_char);
                    $display("          actual   echo=%0d/%0b last=%0b enter=%0b cursor=%0d length=%0d read=%0d",
                             got.echo_char, got.echo_valid, got.last, got.enter_seen,
                             got.cursor_pos, got.line_length, got.read_char);
                end
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top of the line editor testbench: clock, reset, keystroke driver, result monitor and run control.
module testbench;
    import tle_pkg::*;
    import line_editor_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A correct run stays well under this limit, even with three echo bytes per item each
    // waiting out a heavy stall; the limit leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 30;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HEAVY
    } stall_mode_e;

    // Every input of the block holds a known value from time zero.
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_func       = FUNC_KEY;
    logic [7:0] i_key_code   = KEY_NONE;
    logic [7:0] i_read_index = 8'd0;
    logic       o_out_valid;
    logic       i_out_stall  = 1'b0;
    logic [7:0] o_echo_char;
    logic       o_echo_valid;
    logic       o_last;
    logic       o_enter_seen;
    logic [8:0] o_cursor_pos;
    logic [8:0] o_line_length;
    logic [7:0] o_read_char;

    line_scoreboard sb;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    stall_mode_e stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    terminal_line_editor #(
        .LINE_CAPACITY(LINE_CAP)
    ) dut (.*);

    // Clock with a period of 2 ns.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The run is stopped here if the results never drain; a hang counts as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver has its own stall pattern: it switches between stretches with no stall
    // at all, occasional single stalls and heavy stalling. The stall changes only at the
    // falling edge, so it is settled when the block samples it.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 2));
            stall_left = $urandom_range(16, 64);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:   i_out_stall = 1'b0;
            STALL_SPARSE: i_out_stall = ($urandom_range(0, 3) == 0);
            default:      i_out_stall = ($urandom_range(0, 1) == 1);
        endcase
    end

    // A result transfer happens at a rising edge with valid high and stall low. The values
    // read here are those that have been stable since the preceding falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{echo_char:   o_echo_char,
                              echo_valid:  o_echo_valid,
                              last:        o_last,
                              enter_seen:  o_enter_seen,
                              cursor_pos:  o_cursor_pos,
                              line_length: o_line_length,
                              read_char:   o_read_char});
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one item. It is entered at a falling edge and returns at a falling edge, so the
    // valid line and the payload get exactly one assignment per time step. The sender works
    // in bursts; between bursts it may leave a gap with valid low. The payload is held
    // until the transfer, however long the block stalls.
    task automatic send_item(input logic [1:0] func, input logic [7:0] key,
                             input logic [7:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   = 1'b1;
        i_func       = func;
        i_key_code   = key;
        i_read_index = idx;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_item(func, key, idx);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic press(input logic [7:0] key);
        send_item(FUNC_KEY, key, rand8());
    endtask

    // A complete cursor sequence: ESC, bracket and the final letter.
    task automatic arrow(input logic [7:0] key);
        press(KEY_ESC);
        press(KEY_BRACKET);
        press(key);
    endtask

    task automatic printable();
        press(8'($urandom_range(KEY_SPACE, KEY_TILDE)));
    endtask

    // The sender holds off until every expected result has arrived, then a little longer.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Directed opening: the empty line, every selector, the cursor at both ends, a repeated
    // bracket, broken escapes from both pending phases, newline and ignored control codes.
    task automatic directed_items();
        send_item(FUNC_READ, 8'd255, 8'd0);       // read of an empty line
        press(KEY_NONE);
        send_item(FUNC_SPARE, 8'd255, 8'd255);
        press(KEY_BS);                            // backspace at the start does nothing
        arrow(KEY_LEFT);                          // left at column zero, no echo
        press(KEY_SPACE);
        press(KEY_TILDE);
        press(KEY_ESC);                           // ESC [ [ D: the second bracket is kept
        press(KEY_BRACKET);
        press(KEY_BRACKET);
        press(KEY_LEFT);
        press(8'd90);                             // overwrite inside the line
        arrow(KEY_RIGHT);                         // right at the end of the line, no echo
        arrow(KEY_UP);                            // swallowed
        press(KEY_ESC);                           // broken after ESC: q is appended
        press(8'd113);
        press(KEY_ESC);                           // broken after ESC [: delete still works
        press(KEY_BRACKET);
        press(KEY_DEL);
        press(KEY_NL);
        press(8'd1);                              // other control codes are ignored
        send_item(FUNC_READ, 8'd0, 8'd1);
        send_item(FUNC_READ, 8'd0, 8'd255);       // beyond the length
        send_item(FUNC_FLUSH, 8'd170, 8'd85);
    endtask

    // Fills the line to capacity, then tries appends that must be refused, moves about at
    // the full end and overwrites the last byte before reading both ends.
    task automatic fill_line();
        send_item(FUNC_FLUSH, rand8(), rand8());
        while (sb.get_len() < LINE_CAP)
            printable();
        repeat (3) printable();
        arrow(KEY_LEFT);
        printable();
        arrow(KEY_RIGHT);
        printable();
        send_item(FUNC_READ, rand8(), 8'd255);
        send_item(FUNC_READ, rand8(), 8'd0);
        send_item(FUNC_FLUSH, rand8(), rand8());
    endtask

    // One random step. Most steps are well-formed edits and cursor sequences with random
    // content; the rest are broken escapes, noise keys and random selectors.
    task automatic random_step();
        int         pick;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            printable();
        end else if (pick < 42) begin
            arrow(($urandom_range(0, 1) == 1) ? KEY_LEFT : KEY_RIGHT);
        end else if (pick < 45) begin
            arrow(KEY_UP);
        end else if (pick < 53) begin
            press(($urandom_range(0, 1) == 1) ? KEY_DEL : KEY_BS);
        end else if (pick < 57) begin
            press(KEY_NL);
        end else if (pick < 68) begin
            // Mostly reads inside the line, sometimes anywhere.
            if (sb.get_len() == 0 || $urandom_range(0, 3) == 0)
                idx = rand8();
            else
                idx = 8'($urandom_range(0, sb.get_len() - 1));
            send_item(FUNC_READ, rand8(), idx);
        end else if (pick < 71) begin
            send_item(FUNC_FLUSH, rand8(), rand8());
        end else if (pick < 75) begin
            press(KEY_ESC);
            press(rand8());
        end else if (pick < 79) begin
            press(KEY_ESC);
            press(KEY_BRACKET);
            press(rand8());
        end else if (pick < 88) begin
            press(rand8());
        end else if (pick < 94) begin
            send_item(2'($urandom_range(0, 3)), rand8(), rand8());
        end else begin
            press(KEY_NONE);
        end
    endtask

    task automatic random_items(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            random_step();
    endtask

    initial begin
        sb = new();
        // Synchronous reset, released at a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_items();
        wait_drained();
        random_items(RANDOM_ITEMS / 2);
        wait_drained();
        fill_line();
        random_items(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        // All stimulus is in; wait for the last results and a few quiet cycles.
        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
